>>> rtl/linear_quadtree_cell_register_assert.svh
// Assertion macros for the linear quadtree cell register.
`ifndef LINEAR_QUADTREE_CELL_REGISTER_ASSERT_SVH
`define LINEAR_QUADTREE_CELL_REGISTER_ASSERT_SVH

`ifndef SYNTHESIS
// Same-cycle implication, disabled in reset.
`define LQCR_ASSERT_NOW(label, cond, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (expr)) \
        else $error("lqcr assertion failed");
// Next-cycle implication, disabled in reset.
`define LQCR_ASSERT_NEXT(label, cond, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (expr)) \
        else $error("lqcr assertion failed");
`else
`define LQCR_ASSERT_NOW(label, cond, expr)
`define LQCR_ASSERT_NEXT(label, cond, expr)
`endif

`endif

>>> rtl/lqcr_pkg.sv
// Types, constants and helper functions for the linear quadtree cell register.
package lqcr_pkg;

    localparam int COORD_W           = 8;
    localparam int CODE_W            = 2 * COORD_W;
    localparam int PAIRS             = COORD_W;
    localparam int PAIR_IDX_W        = $clog2(PAIRS);
    localparam int INDEX_W           = 17;
    localparam int LEVEL_W           = 4;
    localparam int MASK_W            = 4;
    localparam int DEPTH_W           = 4;
    localparam int MAX_DEPTH_DEFAULT = 8;

    localparam logic [DEPTH_W-1:0] DEPTH_RESET = 4'd8;

    localparam logic [MASK_W-1:0] QUAD_ALL    = 4'b1111;
    localparam logic [MASK_W-1:0] QUAD_X_LOW  = 4'b0101;
    localparam logic [MASK_W-1:0] QUAD_X_HIGH = 4'b1010;
    localparam logic [MASK_W-1:0] QUAD_Z_LOW  = 4'b0011;
    localparam logic [MASK_W-1:0] QUAD_Z_HIGH = 4'b1100;
    localparam logic [1:0]        PAIR_NONE   = 2'b00;

    typedef struct packed {
        logic [COORD_W-1:0] min_cell_x;
        logic [COORD_W-1:0] min_cell_z;
        logic [COORD_W-1:0] max_cell_x;
        logic [COORD_W-1:0] max_cell_z;
    } lqcr_box_t;

    typedef struct packed {
        logic               accepted;
        logic [INDEX_W-1:0] node_index;
        logic [LEVEL_W-1:0] node_level;
        logic [MASK_W-1:0]  quadrant_mask;
    } lqcr_node_t;

    // Place coordinate bits on even positions.
    function automatic logic [CODE_W-1:0] spread_bits(input logic [COORD_W-1:0] v);
        logic [CODE_W-1:0] r;
        r = '0;
        for (int i = 0; i < COORD_W; i++)
        begin
            r[2*i] = v[i];
        end
        return r;
    endfunction

    // First linear index of a level, (4^lv - 1) / 3, kept to INDEX_W bits.
    function automatic logic [INDEX_W-1:0] level_start(input logic [LEVEL_W-1:0] lv);
        logic [INDEX_W-1:0] s;
        unique case (lv)
            4'd0:    s = 17'd0;
            4'd1:    s = 17'd1;
            4'd2:    s = 17'd5;
            4'd3:    s = 17'd21;
            4'd4:    s = 17'd85;
            4'd5:    s = 17'd341;
            4'd6:    s = 17'd1365;
            4'd7:    s = 17'd5461;
            4'd8:    s = 17'd21845;
            default: s = 17'd87381;
        endcase
        return s;
    endfunction

endpackage

>>> rtl/linear_quadtree_cell_register.sv
// Top level of the linear quadtree cell register.
// box_reg holds a taken box, node_reg then its node; done is high one cycle per node.
// Throughput: one box per cycle; busy stays low, the two-register pipeline never stalls.
// The depth of the path is the Morton prefix search plus the 17-bit index add.
// Reset clears both valid flags and sets depth_reg to 8.
`include "linear_quadtree_cell_register_assert.svh"

module linear_quadtree_cell_register #(
    parameter int MAX_DEPTH = lqcr_pkg::MAX_DEPTH_DEFAULT
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    output logic                         busy,
    input  lqcr_pkg::lqcr_box_t          box,
    input  logic                         cfg_wr_en,
    input  logic [lqcr_pkg::DEPTH_W-1:0] cfg_wr_data,
    output logic                         done,
    output lqcr_pkg::lqcr_node_t         node
);
    import lqcr_pkg::*;

    logic               take;
    logic               in_valid_reg;
    logic               in_valid_next;
    lqcr_box_t          box_reg;
    logic [DEPTH_W-1:0] depth_reg;
    logic [DEPTH_W-1:0] depth_next;
    logic               done_reg;
    logic               done_next;
    lqcr_node_t         node_reg;
    lqcr_node_t         node_next;

    assign busy          = 1'b0;
    assign take          = start && !busy;
    assign in_valid_next = take;
    assign done_next     = in_valid_reg;
    assign depth_next    = cfg_wr_en ? cfg_wr_data : depth_reg;

    lqcr_node_find #(
        .MAX_DEPTH(MAX_DEPTH)
    ) u_node_find (
        .depth(depth_reg),
        .box  (box_reg),
        .node (node_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
            done_reg     <= 1'b0;
            depth_reg    <= DEPTH_RESET;
        end
        else
        begin
            in_valid_reg <= in_valid_next;
            done_reg     <= done_next;
            depth_reg    <= depth_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            box_reg <= box;
        end
        if (in_valid_reg)
        begin
            node_reg <= node_next;
        end
    end

    assign done = done_reg;
    assign node = node_reg;

    `LQCR_ASSERT_NEXT(a_take_loads, take, in_valid_reg)
    `LQCR_ASSERT_NEXT(a_pipe_delivers, in_valid_reg, done)
    `LQCR_ASSERT_NOW(a_reject_zero, done && !node.accepted, node == '0)
    `LQCR_ASSERT_NOW(a_level_cap, done && node.accepted, node.node_level <= LEVEL_W'(MAX_DEPTH))

endmodule

>>> rtl/lqcr_node_find.sv
// Morton interleave, common-prefix search and node/quadrant derivation for one box.
module lqcr_node_find #(
    parameter int MAX_DEPTH = lqcr_pkg::MAX_DEPTH_DEFAULT
) (
    input  logic [lqcr_pkg::DEPTH_W-1:0] depth,
    input  lqcr_pkg::lqcr_box_t          box,
    output lqcr_pkg::lqcr_node_t         node
);
    import lqcr_pkg::*;

    localparam logic [DEPTH_W-1:0] DEPTH_CAP = DEPTH_W'(MAX_DEPTH);

    logic [DEPTH_W-1:0]    depth_eff;
    logic                  in_range;
    logic [CODE_W-1:0]     code_min;
    logic [CODE_W-1:0]     code_max;
    logic [CODE_W-1:0]     diff;
    logic [LEVEL_W-1:0]    shift;
    logic [LEVEL_W-1:0]    level;
    logic [PAIR_IDX_W-1:0] pair_sel;
    logic [1:0]            pmin;
    logic [1:0]            pmax_inv;
    logic [MASK_W-1:0]     mask;
    logic [INDEX_W-1:0]    index;

    assign depth_eff = (depth > DEPTH_CAP) ? DEPTH_CAP : depth;

    assign in_range = ((box.min_cell_x >> depth_eff) == '0)
                   && ((box.min_cell_z >> depth_eff) == '0)
                   && ((box.max_cell_x >> depth_eff) == '0)
                   && ((box.max_cell_z >> depth_eff) == '0);

    assign code_min = spread_bits(box.min_cell_x) | (spread_bits(box.min_cell_z) << 1);
    assign code_max = spread_bits(box.max_cell_x) | (spread_bits(box.max_cell_z) << 1);
    assign diff     = code_min ^ code_max;

    // Highest differing pair, counted from 1; 0 when codes match.
    always_comb
    begin
        shift = '0;
        for (int i = 0; i < PAIRS; i++)
        begin
            if (diff[2*i +: 2] != PAIR_NONE)
            begin
                shift = LEVEL_W'(i + 1);
            end
        end
    end

    assign level    = depth_eff - shift;
    assign pair_sel = PAIR_IDX_W'(shift - 4'd1);
    assign pmin     = code_min[2*pair_sel +: 2];
    assign pmax_inv = ~code_max[2*pair_sel +: 2];

    always_comb
    begin
        mask = QUAD_ALL;
        if (shift != '0)
        begin
            if (pmin[0])
            begin
                mask = mask & ~QUAD_X_LOW;
            end
            if (pmax_inv[0])
            begin
                mask = mask & ~QUAD_X_HIGH;
            end
            if (pmin[1])
            begin
                mask = mask & ~QUAD_Z_LOW;
            end
            if (pmax_inv[1])
            begin
                mask = mask & ~QUAD_Z_HIGH;
            end
        end
    end

    assign index = INDEX_W'(code_min >> {shift, 1'b0}) + level_start(level);

    always_comb
    begin
        if (in_range)
        begin
            node.accepted      = 1'b1;
            node.node_index    = index;
            node.node_level    = level;
            node.quadrant_mask = mask;
        end
        else
        begin
            node = '0;
        end
    end

endmodule
